>>> sv/kbsrt_pkg.sv
// package for the keyed best score rank table
`default_nettype none
package kbsrt_pkg;
  localparam int MaxPlayers = 16;
  localparam int UidMaxBytes = 8;

  localparam logic [1:0] ModeSelect = 2'd0;
  localparam logic [1:0] ModeSubmit = 2'd1;
  localparam logic [1:0] ModeQuery  = 2'd2;
  localparam logic [1:0] ModeRead   = 2'd3;

  typedef struct packed {
    logic load;      // capture input beat, clear walk index
    logic scan_step; // key search step
    logic sort_init; // order[i] = i
    logic sort_step; // one compare or index advance of exchange sort
    logic rank_init; // pick target score, clear walk index
    logic rank_step; // rank count step
    logic finish;    // apply result and write output register
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic sort_done;
    logic rank_done;
    logic need_sort;
  } sts_t;

  function automatic logic [63:0] len_mask(input logic [3:0] len);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (b < len) m[b*8 +: 8] = 8'hff;
    end
    return m;
  endfunction
endpackage
`default_nettype wire

>>> sv/kbsrt_ctrl.sv
// controller state machine of the rank table
`default_nettype none
module kbsrt_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              valid,
  output logic             ready,
  input  wire              out_busy,
  input  kbsrt_pkg::sts_t  sts,
  output kbsrt_pkg::cmd_t  cmd
);
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_INIT  = 7'b0000100,
    S_SORT  = 7'b0001000,
    S_RINIT = 7'b0010000,
    S_RANK  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    ready = 1'b0;
    case (state)
      S_IDLE: begin
        ready = 1'b1;
        if (valid) begin
          cmd.load = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) state_next = sts.need_sort ? S_INIT : S_RINIT;
      end
      S_INIT: begin
        cmd.sort_init = 1'b1;
        state_next = S_SORT;
      end
      S_SORT: begin
        cmd.sort_step = 1'b1;
        if (sts.sort_done) state_next = S_DONE;
      end
      S_RINIT: begin
        cmd.rank_init = 1'b1;
        state_next = S_RANK;
      end
      S_RANK: begin
        cmd.rank_step = 1'b1;
        if (sts.rank_done) state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) cmd.load |=> state == S_SCAN)
    else $error("load did not start scan");
  assert property (@(posedge clk) disable iff (rst) $onehot0(cmd))
    else $error("more than one command");
  assert property (@(posedge clk) disable iff (rst) cmd.finish |-> !out_busy)
    else $error("finish while output held");
endmodule
`default_nettype wire

>>> sv/kbsrt_dp.sv
// datapath: entry store, key search, rank count, exchange sort
`default_nettype none
module kbsrt_dp #(
  parameter int MAX_PLAYERS = kbsrt_pkg::MaxPlayers,
  parameter int UID_MAX_BYTES = kbsrt_pkg::UidMaxBytes,
  localparam int IW = (MAX_PLAYERS > 1) ? $clog2(MAX_PLAYERS) : 1,
  localparam int CW = $clog2(MAX_PLAYERS + 1)
) (
  input  wire              clk,
  input  wire              rst,
  input  kbsrt_pkg::cmd_t  cmd,
  output kbsrt_pkg::sts_t  sts,
  input  wire [1:0]        mode,
  input  wire [63:0]       key_bytes,
  input  wire [3:0]        key_length,
  input  wire [15:0]       new_score,
  input  wire [3:0]        rank_position,
  input  wire              write_ok,
  output logic             r_ok,
  output logic [15:0]      r_best,
  output logic [4:0]       r_rank,
  output logic [4:0]       r_count,
  output logic [63:0]      r_key,
  output logic [3:0]       r_klen
);
  logic [63:0] keys [MAX_PLAYERS];
  logic [3:0]  klens [MAX_PLAYERS];
  logic [15:0] scores [MAX_PLAYERS];
  logic [IW-1:0] order [MAX_PLAYERS];

  logic [CW-1:0] count;
  logic [IW-1:0] cur;
  logic          cur_valid;

  logic [1:0]  m;
  logic [63:0] k;
  logic [3:0]  kl;
  logic [15:0] sc;
  logic [3:0]  rp;
  logic        wok;

  logic [CW-1:0] idx;
  logic [CW-1:0] jdx;
  logic          found;
  logic [IW-1:0] found_slot;
  logic [15:0]   cur_score;
  logic [CW-1:0] higher;
  logic [15:0]   target;

  logic kl_good;
  assign kl_good = (kl != 4'd0) && ({28'd0, kl} <= UID_MAX_BYTES);

  logic [IW-1:0] idx_i;
  assign idx_i = idx[IW-1:0];

  // every walk covers all count entries; cur_score taken at load time
  assign sts.scan_done = (idx >= count);
  assign sts.need_sort = (m == kbsrt_pkg::ModeRead) && ({28'd0, rp} < 32'(count));
  assign sts.sort_done = (idx >= count);
  assign sts.rank_done = (idx >= count);

  // whether a submit raises the score, and the resulting current score
  logic [15:0] sub_score;
  logic        raise;
  assign raise = (m == kbsrt_pkg::ModeSubmit) && cur_valid && (sc > cur_score);
  assign sub_score = raise ? sc : cur_score;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      cur <= '0;
      cur_valid <= 1'b0;
    end else if (cmd.load) begin
      m <= mode;
      k <= key_bytes & kbsrt_pkg::len_mask(key_length);
      kl <= key_length;
      sc <= new_score;
      rp <= rank_position;
      wok <= write_ok;
      idx <= '0;
      found <= 1'b0;
      cur_score <= scores[cur];
    end else if (cmd.scan_step) begin
      if (!sts.scan_done) begin
        if (!found && klens[idx_i] == kl && keys[idx_i] == k) begin
          found <= 1'b1;
          found_slot <= idx_i;
        end
        idx <= idx + 1'b1;
      end
    end else if (cmd.sort_init) begin
      for (int i = 0; i < MAX_PLAYERS; i++) order[i] <= IW'(i);
      idx <= '0;
      jdx <= CW'(1);
    end else if (cmd.sort_step) begin
      if (!sts.sort_done) begin
        if (jdx < count) begin
          if (scores[order[jdx[IW-1:0]]] > scores[order[idx_i]]) begin
            order[idx_i] <= order[jdx[IW-1:0]];
            order[jdx[IW-1:0]] <= order[idx_i];
          end
          jdx <= jdx + 1'b1;
        end else begin
          idx <= idx + 1'b1;
          jdx <= idx + CW'(2);
        end
      end
    end else if (cmd.rank_init) begin
      // score of the current entry as it stands after this item
      if (m == kbsrt_pkg::ModeSelect) target <= found ? scores[found_slot] : '0;
      else target <= sub_score;
      idx <= '0;
      higher <= '0;
    end else if (cmd.rank_step) begin
      if (!sts.rank_done) begin
        if (scores[idx_i] > target) higher <= higher + 1'b1;
        idx <= idx + 1'b1;
      end
    end else if (cmd.finish) begin
      if (m == kbsrt_pkg::ModeSelect && kl_good) begin
        if (found) begin
          cur <= found_slot;
          cur_valid <= 1'b1;
        end else if (32'(count) < MAX_PLAYERS) begin
          if (wok) begin
            keys[count[IW-1:0]] <= k;
            klens[count[IW-1:0]] <= kl;
            scores[count[IW-1:0]] <= '0;
            cur <= count[IW-1:0];
            cur_valid <= 1'b1;
            count <= count + 1'b1;
          end else begin
            cur <= '0;
            cur_valid <= 1'b0;
          end
        end
      end
      if (raise) scores[cur] <= sc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      r_ok <= 1'b0;
      r_best <= '0;
      r_rank <= '0;
      r_key <= '0;
      r_klen <= '0;
      r_count <= 5'(count);
      case (m)
        kbsrt_pkg::ModeSelect: begin
          if (kl_good) begin
            if (found) begin
              r_ok <= 1'b1;
              r_best <= target;
              r_rank <= 5'(higher) + 5'd1;
            end else if (32'(count) < MAX_PLAYERS && wok) begin
              r_ok <= 1'b1;
              r_rank <= 5'(higher) + 5'd1;
              r_count <= 5'(count + 1'b1);
            end
          end
        end
        kbsrt_pkg::ModeSubmit: begin
          if (cur_valid) begin
            r_ok <= raise ? wok : 1'b1;
            if (!raise || wok) begin
              r_best <= target;
              r_rank <= 5'(higher) + 5'd1;
            end
          end
        end
        kbsrt_pkg::ModeQuery: begin
          if (cur_valid) begin
            r_ok <= 1'b1;
            r_best <= target;
            r_rank <= 5'(higher) + 5'd1;
          end
        end
        default: begin
          if (sts.need_sort) begin
            r_ok <= 1'b1;
            r_best <= scores[order[rp[IW-1:0]]];
            r_rank <= 5'(rp) + 5'd1;
            r_key <= keys[order[rp[IW-1:0]]]
                     & kbsrt_pkg::len_mask(klens[order[rp[IW-1:0]]]);
            r_klen <= klens[order[rp[IW-1:0]]];
          end
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) 32'(count) <= MAX_PLAYERS)
    else $error("count beyond capacity");
  assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> 32'(cur) < 32'(count))
    else $error("current slot outside table");
  assert property (@(posedge clk) disable iff (rst)
    cmd.finish && m == kbsrt_pkg::ModeSelect && !kl_good |=> $stable(count))
    else $error("bad length changed table");
endmodule
`default_nettype wire

>>> sv/keyed_best_score_rank_table.sv
// top level of the keyed best score rank table
//   channel | handshake             | payload
//   input   | valid / ready         | mode key_bytes key_length new_score rank_position write_ok
//   output  | out_valid / out_ready | ok best_score rank player_count entry_key entry_key_length
// one item at a time; select, submit, query and failed reads: key search walk, then rank
// count walk; the next item can be accepted in the same cycle as the result appears
// read by rank: key search walk, then order init and exchange sort walk, the worst case
// reset clears count and current entry; entries are undefined until written
// a held result stalls the next item only at its final write
`default_nettype none
module keyed_best_score_rank_table #(
  parameter int MAX_PLAYERS = kbsrt_pkg::MaxPlayers,
  parameter int UID_MAX_BYTES = kbsrt_pkg::UidMaxBytes
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         valid,
  output logic        ready,
  input  wire [1:0]   mode,
  input  wire [63:0]  key_bytes,
  input  wire [3:0]   key_length,
  input  wire [15:0]  new_score,
  input  wire [3:0]   rank_position,
  input  wire         write_ok,
  output logic        out_valid,
  input  wire         out_ready,
  output logic        ok,
  output logic [15:0] best_score,
  output logic [4:0]  rank,
  output logic [4:0]  player_count,
  output logic [63:0] entry_key,
  output logic [3:0]  entry_key_length
);
  kbsrt_pkg::cmd_t cmd;
  kbsrt_pkg::sts_t sts;

  kbsrt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .valid(valid), .ready(ready),
    .out_busy(out_valid && !out_ready), .sts(sts), .cmd(cmd)
  );

  kbsrt_dp #(.MAX_PLAYERS(MAX_PLAYERS), .UID_MAX_BYTES(UID_MAX_BYTES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .mode(mode), .key_bytes(key_bytes), .key_length(key_length),
    .new_score(new_score), .rank_position(rank_position), .write_ok(write_ok),
    .r_ok(ok), .r_best(best_score), .r_rank(rank), .r_count(player_count),
    .r_key(entry_key), .r_klen(entry_key_length)
  );

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.finish) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end
endmodule
`default_nettype wire

>>> test/kbsrt_checker.sv
// checker for the keyed best score rank table: predicts each result beat and compares it
module kbsrt_checker (
  input  wire         clk,
  input  wire         rst,
  input  wire         valid,
  input  wire         ready,
  input  wire [1:0]   mode,
  input  wire [63:0]  key_bytes,
  input  wire [3:0]   key_length,
  input  wire [15:0]  new_score,
  input  wire [3:0]   rank_position,
  input  wire         write_ok,
  input  wire         out_valid,
  input  wire         out_ready,
  input  wire         ok,
  input  wire [15:0]  best_score,
  input  wire [4:0]   rank,
  input  wire [4:0]   player_count,
  input  wire [63:0]  entry_key,
  input  wire [3:0]   entry_key_length,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        ok;
    logic [15:0] best;
    logic [4:0]  rank;
    logic [4:0]  count;
    logic [63:0] key;
    logic [3:0]  klen;
  } table_result_t;

  logic [63:0] keys [kbsrt_pkg::MaxPlayers];
  logic [3:0]  klens [kbsrt_pkg::MaxPlayers];
  logic [15:0] scores [kbsrt_pkg::MaxPlayers];
  int          n_entries;
  int          cur;
  logic        cur_valid;
  table_result_t expected_results[$];

  function automatic logic [63:0] byte_mask(input logic [3:0] len);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) if (b < len) m[b*8 +: 8] = 8'hff;
    return m;
  endfunction

  function automatic table_result_t predict_table(input logic [1:0] md, input logic [63:0] kb,
      input logic [3:0] kl, input logic [15:0] sc, input logic [3:0] rp, input logic wok);
    table_result_t r;
    logic        found;
    logic [63:0] k;
    int          order [kbsrt_pkg::MaxPlayers];
    int          t;
    int          sel;
    r = '0;
    found = 0;
    if (md == kbsrt_pkg::ModeSelect) begin
      if (kl != 0 && kl <= kbsrt_pkg::UidMaxBytes) begin
        k = kb & byte_mask(kl);
        for (int i = 0; i < n_entries; i++) begin
          if (!found && klens[i] == kl && keys[i] == k) begin
            cur = i;
            cur_valid = 1;
            found = 1;
            r.ok = 1;
          end
        end
        if (!found && n_entries < kbsrt_pkg::MaxPlayers) begin
          if (wok) begin
            keys[n_entries] = k;
            klens[n_entries] = kl;
            scores[n_entries] = '0;
            cur = n_entries;
            cur_valid = 1;
            n_entries++;
            r.ok = 1;
          end else begin
            cur_valid = 0;
            cur = 0;
          end
        end
      end
    end else if (md == kbsrt_pkg::ModeSubmit) begin
      if (cur_valid) begin
        if (sc <= scores[cur]) r.ok = 1;
        else begin
          scores[cur] = sc;
          r.ok = wok;
        end
      end
    end else if (md == kbsrt_pkg::ModeQuery) begin
      r.ok = cur_valid;
    end else if (rp < n_entries) begin
      for (int i = 0; i < n_entries; i++) order[i] = i;
      for (int i = 0; i < n_entries; i++)
        for (int j = i + 1; j < n_entries; j++)
          if (scores[order[j]] > scores[order[i]]) begin
            t = order[i];
            order[i] = order[j];
            order[j] = t;
          end
      sel = order[rp];
      r.ok = 1;
      r.best = scores[sel];
      r.rank = 5'(rp) + 5'd1;
      r.key = keys[sel] & byte_mask(klens[sel]);
      r.klen = klens[sel];
    end
    if (md != kbsrt_pkg::ModeRead && r.ok && cur_valid) begin
      r.best = scores[cur];
      r.rank = 1;
      for (int i = 0; i < n_entries; i++) if (scores[i] > scores[cur]) r.rank++;
    end
    r.count = 5'(n_entries);
    return r;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    table_result_t e;
    if (rst) begin
      n_entries = 0;
      cur = 0;
      cur_valid = 0;
      fail_count = 0;
      expected_results.delete();
    end else begin
      if (valid && ready)
        expected_results.push_back(predict_table(mode, key_bytes, key_length, new_score,
                                                 rank_position, write_ok));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no expectation");
          fail_count++;
        end else begin
          e = expected_results.pop_front();
          if (ok !== e.ok) begin
            $error("ok: expected %0d actual %0d", e.ok, ok); fail_count++;
          end
          if (best_score !== e.best) begin
            $error("best_score: expected %0d actual %0d", e.best, best_score); fail_count++;
          end
          if (rank !== e.rank) begin
            $error("rank: expected %0d actual %0d", e.rank, rank); fail_count++;
          end
          if (player_count !== e.count) begin
            $error("player_count: expected %0d actual %0d", e.count, player_count);
            fail_count++;
          end
          if (entry_key !== e.key) begin
            $error("entry_key: expected %h actual %h", e.key, entry_key); fail_count++;
          end
          if (entry_key_length !== e.klen) begin
            $error("entry_key_length: expected %0d actual %0d", e.klen, entry_key_length);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

>>> test/tb_keyed_best_score_rank_table.sv
// testbench top for the keyed best score rank table: stimulus, idling and verdict
module tb_keyed_best_score_rank_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 20000;

  logic        clk = 0;
  logic        rst = 1;
  logic        valid = 0;
  logic        ready;
  logic [1:0]  mode = kbsrt_pkg::ModeQuery;
  logic [63:0] key_bytes = '0;
  logic [3:0]  key_length = '0;
  logic [15:0] new_score = '0;
  logic [3:0]  rank_position = '0;
  logic        write_ok = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic        ok;
  logic [15:0] best_score;
  logic [4:0]  rank;
  logic [4:0]  player_count;
  logic [63:0] entry_key;
  logic [3:0]  entry_key_length;
  int          fail_count;
  int          pending;
  int          idle_cycles = 0;
  int          burst_left = 0;
  logic [63:0] key_pool [24];
  logic [3:0]  klen_pool [24];

  always #5 clk = ~clk;

  keyed_best_score_rank_table dut (.*);
  kbsrt_checker u_checker (.*);

  always @(posedge clk) begin
    if (!rst && !((valid && ready) || (out_valid && out_ready))) idle_cycles++;
    else idle_cycles = 0;
    if (idle_cycles >= StallLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver stall pattern: phases of always-ready and of random stalls
  initial begin
    int phase;
    forever begin
      @(negedge clk);
      phase = ($urandom_range(0, 199) == 0) ? $urandom_range(0, 2) : phase;
      case (phase)
        0: out_ready <= 1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic send_beat(input logic [1:0] md, input logic [63:0] kb, input logic [3:0] kl,
                           input logic [15:0] sc, input logic [3:0] rp, input logic wok);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        valid <= 0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    valid <= 1;
    mode <= md;
    key_bytes <= kb;
    key_length <= kl;
    new_score <= sc;
    rank_position <= rp;
    write_ok <= wok;
    do @(posedge clk); while (!ready);
    @(negedge clk);
  endtask

  // drop valid and wait until every expected result has come
  task automatic drain();
    valid <= 0;
    burst_left = 0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic random_beat();
    int pick;
    int r;
    pick = $urandom_range(0, 23);
    r = $urandom_range(0, 99);
    if (r < 35)
      send_beat(kbsrt_pkg::ModeSelect, (r < 30) ? (key_pool[pick] | ({$urandom, $urandom}
                & ~kbsrt_pkg::len_mask(klen_pool[pick]))) : {$urandom, $urandom},
                (r < 32) ? klen_pool[pick] : 4'($urandom), 16'($urandom), 4'($urandom),
                ($urandom_range(0, 5) != 0));
    else if (r < 65)
      send_beat(kbsrt_pkg::ModeSubmit, {$urandom, $urandom}, 4'($urandom),
                ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 20)) : 16'($urandom),
                4'($urandom), ($urandom_range(0, 5) != 0));
    else if (r < 75)
      send_beat(kbsrt_pkg::ModeQuery, {$urandom, $urandom}, 4'($urandom), 16'($urandom),
                4'($urandom), 1'($urandom));
    else
      send_beat(kbsrt_pkg::ModeRead, {$urandom, $urandom}, 4'($urandom), 16'($urandom),
                4'($urandom), 1'($urandom));
  endtask

  initial begin
    for (int i = 0; i < 24; i++) begin
      klen_pool[i] = $urandom_range(1, 8);
      key_pool[i] = {$urandom, $urandom} & kbsrt_pkg::len_mask(klen_pool[i]);
    end
    key_pool[0] = '0;
    klen_pool[0] = 1;
    key_pool[1] = '1;
    klen_pool[1] = 8;
    repeat (10) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    // directed: empty table, bad lengths, refused writes, ties, extremes
    send_beat(kbsrt_pkg::ModeSubmit, '0, 4'd1, 16'hffff, 4'd0, 1);
    send_beat(kbsrt_pkg::ModeQuery, '0, 4'd1, 16'd0, 4'd0, 1);
    send_beat(kbsrt_pkg::ModeRead, '0, 4'd0, 16'd0, 4'd0, 1);
    send_beat(kbsrt_pkg::ModeSelect, '1, 4'd0, 16'd0, 4'd0, 1);
    send_beat(kbsrt_pkg::ModeSelect, '1, 4'd9, 16'd0, 4'd0, 1);
    send_beat(kbsrt_pkg::ModeSelect, '1, 4'd15, 16'd0, 4'd15, 1);
    send_beat(kbsrt_pkg::ModeSelect, 64'h5a, 4'd1, 16'd0, 4'd0, 0);
    send_beat(kbsrt_pkg::ModeSubmit, '0, 4'd0, 16'd7, 4'd0, 1);
    send_beat(kbsrt_pkg::ModeSelect, 64'hffff_ffff_ffff_ff00, 4'd1, 16'd0, 4'd0, 1);
    send_beat(kbsrt_pkg::ModeSubmit, '0, 4'd0, 16'd0, 4'd0, 0);
    send_beat(kbsrt_pkg::ModeSubmit, '0, 4'd0, 16'd100, 4'd0, 0);
    send_beat(kbsrt_pkg::ModeSelect, '1, 4'd8, 16'd0, 4'd0, 1);
    send_beat(kbsrt_pkg::ModeSubmit, '0, 4'd0, 16'hffff, 4'd0, 1);
    send_beat(kbsrt_pkg::ModeSelect, 64'h1234, 4'd2, 16'd0, 4'd0, 1);
    send_beat(kbsrt_pkg::ModeSubmit, '0, 4'd0, 16'd100, 4'd0, 1);
    send_beat(kbsrt_pkg::ModeSelect, 64'h00, 4'd1, 16'd0, 4'd0, 0);
    send_beat(kbsrt_pkg::ModeQuery, '0, 4'd0, 16'd0, 4'd0, 1);
    for (int p = 0; p < 5; p++) send_beat(kbsrt_pkg::ModeRead, '0, 4'd0, 16'd0, 4'(p), 1);
    send_beat(kbsrt_pkg::ModeRead, '0, 4'd0, 16'd0, 4'd15, 1);
    // let everything drain once
    drain();
    for (int n = 0; n < 2000; n++) begin
      random_beat();
      if (n == 1000) drain();
    end
    // fill with fresh keys so the full table is reached
    for (int n = 0; n < 20; n++)
      send_beat(kbsrt_pkg::ModeSelect, {$urandom, $urandom}, 4'($urandom_range(1, 8)),
                16'd0, 4'd0, 1);
    for (int p = 0; p < 16; p++) send_beat(kbsrt_pkg::ModeRead, '0, 4'd0, 16'd0, 4'(p), 1);
    drain();
    repeat (400) @(negedge clk);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
